[rtl/running_min_max_normalizer_unit_defines.svh]
// Assertion macros shared by the normalizer RTL
`ifndef RUNNING_MIN_MAX_NORMALIZER_UNIT_DEFINES_SVH
`define RUNNING_MIN_MAX_NORMALIZER_UNIT_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define NRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check a condition in the cycle after its trigger
`define NRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/nrm_pkg.sv]
// Types, constants and arithmetic helpers of the min/max normalizer
`timescale 1ns / 1ps
`default_nettype none
package nrm_pkg;

  localparam int IDX_W       = 8;
  localparam int SAMPLE_W    = 32;
  localparam int GAIN_W      = 31;
  localparam int OFFS_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int ALPHA_BITS  = 16;
  localparam int DIV_W       = 33;
  localparam int MAX_AW      = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam int ELEMENTS_DEF      = 256;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] WARMUP_RST = 16'd16;
  localparam logic [CFG_W-1:0] ALPHA_RST  = 16'd65209;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARMUP = 2'd0,
    REG_ALPHA  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              active;
    logic [MAX_AW-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             fresh;
    logic [DIV_W-1:0] d;
    logic             sum_pos;
    logic [DIV_W-1:0] mag;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              fresh;
    logic              sum_pos;
    logic [GAIN_W-1:0] gain;
    logic [OFFS_W-1:0] offset;
  } side_t;

  function automatic logic signed [SAMPLE_W-1:0] pull_bound(
    input logic signed [SAMPLE_W-1:0] old,
    input logic signed [SAMPLE_W-1:0] s,
    input logic [ALPHA_BITS:0]        w
  );
    logic signed [SAMPLE_W:0] diff;
    logic signed [50:0]       prod;
    logic signed [50:0]       acc;
    diff = 33'(s) - 33'(old);
    prod = diff * $signed({1'b0, w});
    acc  = (51'(old) <<< ALPHA_BITS) + prod + 51'sd32768;
    return SAMPLE_W'(acc >>> ALPHA_BITS);
  endfunction

  function automatic logic [DIV_W:0] div_step(
    input logic [DIV_W-1:0] rem,
    input logic             nb,
    input logic [DIV_W-1:0] d
  );
    logic [DIV_W:0] t;
    logic [DIV_W:0] r;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      r = {1'b1, DIV_W'(t - {1'b0, d})};
    end else begin
      r = {1'b0, DIV_W'(t)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/nrm_channels.sv]
// Handshake channel interfaces of the normalizer
`timescale 1ns / 1ps
`default_nettype none
interface nrm_in_if;
  logic                                valid;
  logic                                ready;
  logic [nrm_pkg::IDX_W-1:0]           element_index;
  logic signed [nrm_pkg::SAMPLE_W-1:0] sample_value;
  logic                                last_element;
  modport source(output valid, element_index, sample_value, last_element, input ready);
  modport sink(input valid, element_index, sample_value, last_element, output ready);
endinterface

interface nrm_out_if;
  logic                              valid;
  logic                              ready;
  logic [nrm_pkg::IDX_W-1:0]         out_index;
  logic [nrm_pkg::GAIN_W-1:0]        gain;
  logic signed [nrm_pkg::OFFS_W-1:0] offset;
  logic                              fresh;
  modport source(output valid, out_index, gain, offset, fresh, input ready);
  modport sink(input valid, out_index, gain, offset, fresh, output ready);
endinterface

interface nrm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nrm_pkg::CFG_IDX_W-1:0] index;
  logic [nrm_pkg::CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/nrm_front.sv]
// Front end: accepts words, tracks per-element bounds, builds divide jobs
`timescale 1ns / 1ps
`default_nettype none
`include "running_min_max_normalizer_unit_defines.svh"
module nrm_front #(
  parameter int ELEMENTS = nrm_pkg::ELEMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  nrm_in_if.sink        in_ch,
  nrm_cfg_if.sink       cfg,
  output nrm_pkg::clr_t clr,
  output logic          push_valid,
  output nrm_pkg::job_t push_job,
  input  logic          push_ready
);
  import nrm_pkg::*;

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  logic [CFG_W-1:0] alpha;
  logic [CFG_W-1:0] countdown;
  logic             first_vector;
  logic             clearing;
  logic [AW-1:0]    clr_addr;

  logic                       st_v;
  logic                       st_in;
  logic                       st_cz;
  logic                       st_fv;
  logic [IDX_W-1:0]           st_idx;
  logic signed [SAMPLE_W-1:0] st_s;
  logic signed [SAMPLE_W-1:0] rd_hi, rd_lo;
  logic                       fwd_v;
  logic [AW-1:0]              fwd_addr;
  logic signed [SAMPLE_W-1:0] fwd_hi, fwd_lo;

  logic signed [SAMPLE_W-1:0] hi_mem [ELEMENTS];
  logic signed [SAMPLE_W-1:0] lo_mem [ELEMENTS];

  logic                       accept;
  logic                       fire;
  logic                       in_range_in;
  logic [AW-1:0]              in_addr;
  logic [AW-1:0]              st_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic signed [SAMPLE_W-1:0] mem_hi, mem_lo;
  logic signed [SAMPLE_W-1:0] old_hi, old_lo, hi_new, lo_new;
  logic [ALPHA_BITS:0]        weight;
  logic signed [SAMPLE_W+1:0] dd;
  logic signed [SAMPLE_W:0]   sum;

  assign in_ch.ready = !clearing && (!st_v || push_ready);
  assign cfg.ready   = 1'b1;
  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = st_v && push_ready;
  assign in_range_in = 32'(in_ch.element_index) < ELEMENTS;
  assign in_addr     = AW'(in_ch.element_index);
  assign st_addr     = AW'(st_idx);
  assign weight      = (ALPHA_BITS + 1)'(1 << ALPHA_BITS) - (ALPHA_BITS + 1)'(alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= ALPHA_RST;
      countdown    <= WARMUP_RST;
      first_vector <= 1'b1;
    end else begin
      if (accept && in_ch.last_element) begin
        first_vector <= 1'b0;
        if (countdown != '0) begin
          countdown <= countdown - 1'b1;
        end
      end
      if (cfg.valid && cfg.index == REG_WARMUP) begin
        countdown <= cfg.data;
      end
      if (cfg.valid && cfg.index == REG_ALPHA) begin
        alpha <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign clr.active = clearing;
  assign clr.addr   = MAX_AW'(clr_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= 1'b0;
    end else if (in_ch.ready) begin
      st_v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_idx <= in_ch.element_index;
      st_s   <= in_ch.sample_value;
      st_in  <= in_range_in;
      st_cz  <= countdown == '0;
      st_fv  <= first_vector;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hi_mem[mem_addr] <= mem_hi;
      lo_mem[mem_addr] <= mem_lo;
    end
    if (accept) begin
      rd_hi <= hi_mem[in_addr];
      rd_lo <= lo_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      fwd_v <= 1'b0;
    end else if (fire && st_in) begin
      fwd_v    <= 1'b1;
      fwd_addr <= st_addr;
      fwd_hi   <= hi_new;
      fwd_lo   <= lo_new;
    end
  end

  always_comb begin
    if (fwd_v && fwd_addr == st_addr) begin
      old_hi = fwd_hi;
      old_lo = fwd_lo;
    end else begin
      old_hi = rd_hi;
      old_lo = rd_lo;
    end
    if (st_fv) begin
      hi_new = st_s;
      lo_new = st_s;
    end else begin
      hi_new = (st_s > old_hi) ? pull_bound(old_hi, st_s, weight) : old_hi;
      lo_new = (st_s < old_lo) ? pull_bound(old_lo, st_s, weight) : old_lo;
    end
    dd  = 34'(hi_new) - 34'(lo_new) + 34'sd1;
    sum = 33'(hi_new) + 33'(lo_new);
  end

  assign mem_we   = clearing || (fire && st_in);
  assign mem_addr = clearing ? clr_addr : st_addr;
  assign mem_hi   = clearing ? '0 : hi_new;
  assign mem_lo   = clearing ? '0 : lo_new;

  assign push_valid        = st_v;
  assign push_job.idx      = st_idx;
  assign push_job.in_range = st_in;
  assign push_job.fresh    = st_in && st_cz;
  assign push_job.d        = (dd < 34'sd1) ? DIV_W'(1) : DIV_W'(dd);
  assign push_job.sum_pos  = sum > 33'sd0;
  assign push_job.mag      = (sum < 33'sd0) ? DIV_W'(-sum) : DIV_W'(sum);

  `NRM_ASSERT_NEXT(fr_countdown_dec,
    accept && in_ch.last_element && countdown != '0 && !cfg.valid,
    countdown == CFG_W'($past(countdown) - 1'b1), "countdown missed a vector end")
  `NRM_ASSERT_NEXT(fr_first_stays, !first_vector, !first_vector,
    "first vector flag set again")

endmodule
`default_nettype wire

[rtl/nrm_queue.sv]
// Job queue between the front end and the divide back end
`timescale 1ns / 1ps
`default_nettype none
`include "running_min_max_normalizer_unit_defines.svh"
module nrm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  nrm_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output nrm_pkg::job_t pop_job,
  input  logic          pop_ready
);
  import nrm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          push_fire, pop_fire;

  assign push_ready = count != (PW + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `NRM_ASSERT_NEXT(q_fill_count, push_fire && !pop_fire,
    count == (PW + 1)'($past(count) + 1'b1), "queue count lost a push")

endmodule
`default_nettype wire

[rtl/nrm_div.sv]
// Pipelined restoring divider: two quotients over one divisor, one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module nrm_div #(
  parameter int NUM_W = nrm_pkg::FRACTION_BITS_DEF + 33
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [nrm_pkg::DIV_W-1:0] in_d,
  input  logic [NUM_W-1:0]          in_ng,
  input  logic [NUM_W-1:0]          in_no,
  input  nrm_pkg::side_t            in_side,
  output logic                      out_v,
  output logic [NUM_W-1:0]          out_qg,
  output logic [NUM_W-1:0]          out_qo,
  output nrm_pkg::side_t            out_side
);
  import nrm_pkg::*;

  logic             v  [NUM_W];
  logic [DIV_W-1:0] dv [NUM_W];
  logic [DIV_W-1:0] rg [NUM_W];
  logic [DIV_W-1:0] ro [NUM_W];
  logic [NUM_W-1:0] qg [NUM_W];
  logic [NUM_W-1:0] qo [NUM_W];
  side_t            sd [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             pv;
    logic [DIV_W-1:0] pd, prg, pro;
    logic [NUM_W-1:0] pqg, pqo;
    side_t            ps;
    logic [DIV_W:0]   sg, so;

    if (k == 0) begin : g_head
      assign pv  = in_v;
      assign pd  = in_d;
      assign prg = '0;
      assign pro = '0;
      assign pqg = in_ng;
      assign pqo = in_no;
      assign ps  = in_side;
    end else begin : g_body
      assign pv  = v[k-1];
      assign pd  = dv[k-1];
      assign prg = rg[k-1];
      assign pro = ro[k-1];
      assign pqg = qg[k-1];
      assign pqo = qo[k-1];
      assign ps  = sd[k-1];
    end

    assign sg = div_step(prg, pqg[NUM_W-1], pd);
    assign so = div_step(pro, pqo[NUM_W-1], pd);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= pd;
        rg[k] <= sg[DIV_W-1:0];
        ro[k] <= so[DIV_W-1:0];
        qg[k] <= {pqg[NUM_W-2:0], sg[DIV_W]};
        qo[k] <= {pqo[NUM_W-2:0], so[DIV_W]};
        sd[k] <= ps;
      end
    end
  end

  assign out_v    = v[NUM_W-1];
  assign out_qg   = qg[NUM_W-1];
  assign out_qo   = qo[NUM_W-1];
  assign out_side = sd[NUM_W-1];

endmodule
`default_nettype wire

[rtl/nrm_back.sv]
// Back end: coefficient stores, divide pipeline, saturation and result word
`timescale 1ns / 1ps
`default_nettype none
`include "running_min_max_normalizer_unit_defines.svh"
module nrm_back #(
  parameter int ELEMENTS      = nrm_pkg::ELEMENTS_DEF,
  parameter int FRACTION_BITS = nrm_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  nrm_pkg::clr_t clr,
  input  logic          pop_valid,
  input  nrm_pkg::job_t pop_job,
  output logic          pop_ready,
  nrm_out_if.source     out_ch
);
  import nrm_pkg::*;

  localparam int AW    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int NUM_W = FRACTION_BITS + 33;

  logic [GAIN_W-1:0] gain_mem [ELEMENTS];
  logic [OFFS_W-1:0] offs_mem [ELEMENTS];

  logic              en;
  logic              a_v;
  job_t              a_job;
  logic [GAIN_W-1:0] g_rd;
  logic [OFFS_W-1:0] o_rd;
  logic [NUM_W-1:0]  num_g, num_o;
  side_t             a_side;

  logic              ov;
  logic [NUM_W-1:0]  qg, qo, qo_sat;
  side_t             o_side;
  logic [GAIN_W-1:0] g_sat;
  logic [OFFS_W-1:0] o_val;

  logic              st_we;
  logic [AW-1:0]     st_addr;
  logic [GAIN_W-1:0] st_gain;
  logic [OFFS_W-1:0] st_offs;

  assign en        = !ov || out_ch.ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_job <= pop_job;
      g_rd  <= gain_mem[AW'(pop_job.idx)];
      o_rd  <= offs_mem[AW'(pop_job.idx)];
    end
  end

  assign num_g = (NUM_W'(1) << (2 * FRACTION_BITS + 1)) + NUM_W'(a_job.d >> 1);
  assign num_o = (NUM_W'(a_job.mag) << FRACTION_BITS) + NUM_W'(a_job.d >> 1);

  assign a_side.idx     = a_job.idx;
  assign a_side.fresh   = a_job.fresh;
  assign a_side.sum_pos = a_job.sum_pos;
  assign a_side.gain    = a_job.in_range ? g_rd : '0;
  assign a_side.offset  = a_job.in_range ? o_rd : '0;

  nrm_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (a_v),
    .in_d    (a_job.d),
    .in_ng   (num_g),
    .in_no   (num_o),
    .in_side (a_side),
    .out_v   (ov),
    .out_qg  (qg),
    .out_qo  (qo),
    .out_side(o_side)
  );

  always_comb begin
    g_sat = (qg > NUM_W'(32'h7FFF_FFFF)) ? {GAIN_W{1'b1}} : GAIN_W'(qg);
    if (o_side.sum_pos) begin
      qo_sat = (qo > NUM_W'(33'h1_0000_0000 >> 1)) ? NUM_W'(33'h1_0000_0000 >> 1) : qo;
      o_val  = OFFS_W'(NUM_W'(0) - qo_sat);
    end else begin
      qo_sat = (qo > NUM_W'(32'h7FFF_FFFF)) ? NUM_W'(32'h7FFF_FFFF) : qo;
      o_val  = OFFS_W'(qo_sat);
    end
  end

  assign out_ch.valid     = ov;
  assign out_ch.out_index = o_side.idx;
  assign out_ch.fresh     = o_side.fresh;
  assign out_ch.gain      = o_side.fresh ? g_sat : o_side.gain;
  assign out_ch.offset    = o_side.fresh ? o_val : o_side.offset;

  assign st_we   = clr.active || (ov && out_ch.ready && o_side.fresh);
  assign st_addr = clr.active ? AW'(clr.addr) : AW'(o_side.idx);
  assign st_gain = clr.active ? GAIN_W'(1) << FRACTION_BITS : g_sat;
  assign st_offs = clr.active ? '0 : o_val;

  always_ff @(posedge clk) begin
    if (st_we) begin
      gain_mem[st_addr] <= st_gain;
      offs_mem[st_addr] <= st_offs;
    end
  end

  `NRM_ASSERT_NOW(bk_fresh_in_range, out_ch.valid && out_ch.fresh,
    32'(out_ch.out_index) < ELEMENTS, "fresh result for an element outside the store")

endmodule
`default_nettype wire

[rtl/running_min_max_normalizer_unit.sv]
// Result offsets are signed with FRACTION_BITS fraction bits (Q16.16 by default).
// Throughput: one word per cycle while the output is not stalled; set by the one-bit-per-stage divide pipeline.
// A full output stalls the divide pipeline; the front keeps going until the queue fills.
// Reset: synchronous, active high; then a clearing pass over all ELEMENTS entries
// loads the bound and coefficient stores, with no input word taken meanwhile.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none
module running_min_max_normalizer_unit #(
  parameter int ELEMENTS      = nrm_pkg::ELEMENTS_DEF,
  parameter int FRACTION_BITS = nrm_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nrm_in_if.sink    in_ch,
  nrm_out_if.source out_ch,
  nrm_cfg_if.sink   cfg
);
  import nrm_pkg::*;

  clr_t clr;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  nrm_front #(
    .ELEMENTS(ELEMENTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .clr       (clr),
    .push_valid(push_valid),
    .push_job  (push_job),
    .push_ready(push_ready)
  );

  nrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_job  (push_job),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready)
  );

  nrm_back #(
    .ELEMENTS     (ELEMENTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clr      (clr),
    .pop_valid(pop_valid),
    .pop_job  (pop_job),
    .pop_ready(pop_ready),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
